### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### rtl/core/ft8qso_pkg.sv
// ----------------------------------------------------------------------------
// ft8qso_pkg
// Types, codes and the message classifier of the FT8 contact sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ft8qso_pkg;

	localparam int CALL_W = 28;
	localparam int CFG_W  = 28;

	// commands
	localparam logic [2:0] CMD_CQ     = 3'd0;
	localparam logic [2:0] CMD_TOUCH  = 3'd1;
	localparam logic [2:0] CMD_DECODE = 3'd2;
	localparam logic [2:0] CMD_TICK   = 3'd3;
	localparam logic [2:0] CMD_FETCH  = 3'd4;

	// messages
	localparam logic [2:0] MSG_NONE = 3'd0;
	localparam logic [2:0] MSG_TX1  = 3'd1;
	localparam logic [2:0] MSG_TX2  = 3'd2;
	localparam logic [2:0] MSG_TX3  = 3'd3;
	localparam logic [2:0] MSG_TX4  = 3'd4;
	localparam logic [2:0] MSG_TX5  = 3'd5;
	localparam logic [2:0] MSG_CQ   = 3'd6;

	// sequencer states
	localparam logic [2:0] ST_IDLE         = 3'd0;
	localparam logic [2:0] ST_REPLYING     = 3'd1;
	localparam logic [2:0] ST_REPORT       = 3'd2;
	localparam logic [2:0] ST_ROGER_REPORT = 3'd3;
	localparam logic [2:0] ST_ROGERS       = 3'd4;
	localparam logic [2:0] ST_SIGNOFF      = 3'd5;
	localparam logic [2:0] ST_CALLING      = 3'd6;

	// register indexes
	localparam logic [1:0] CFG_MY_CALL     = 2'd0;
	localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
	localparam logic [1:0] CFG_SKIP_FIRST  = 2'd2;
	localparam logic [1:0] CFG_BEACON      = 2'd3;

	localparam logic [3:0]        MAX_RETRIES_RST = 4'd2;
	localparam logic [CALL_W-1:0] CQ_CODE         = 28'd2;

	// report texts, first character in the top byte
	localparam logic [31:0] TEXT_73   = 32'h3733_0000;
	localparam logic [31:0] TEXT_RR73 = 32'h5252_3733;
	localparam logic [31:0] TEXT_RRR  = 32'h5252_5200;
	localparam logic [7:0]  CHAR_R    = 8'h52;

	typedef struct packed {
		logic [2:0]        command;
		logic [CALL_W-1:0] call_to;
		logic [CALL_W-1:0] sender_call;
		logic [31:0]       report_text;
		logic              is_grid;
		logic signed [7:0] decode_snr;
		logic signed [7:0] received_report;
	} req_t;

	typedef struct packed {
		logic              tx_needed;
		logic [2:0]        next_msg;
		logic [2:0]        seq_state;
		logic [3:0]        retry_count;
		logic [CALL_W-1:0] partner_call;
		logic signed [7:0] report_snr;
		logic signed [7:0] partner_report;
		logic              log_pulse;
	} rsp_t;

	// Message kind of a decode; text is cut at its first zero byte
	function automatic logic [2:0] classify(logic [31:0] text, logic grid);
		logic [31:0] s;
		logic [2:0]  kind;
		s = text;
		priority if (text[31:24] == 8'd0) s = 32'd0;
		else if (text[23:16] == 8'd0) s = {text[31:24], 24'd0};
		else if (text[15:8] == 8'd0) s = {text[31:16], 16'd0};
		else if (text[7:0] == 8'd0) s = {text[31:8], 8'd0};
		else s = text;
		priority if (grid) kind = MSG_TX1;
		else if (s == TEXT_73) kind = MSG_TX5;
		else if (s == TEXT_RR73 || s == TEXT_RRR) kind = MSG_TX4;
		else if (s[31:24] == CHAR_R) kind = MSG_TX3;
		else kind = MSG_TX2;
		return kind;
	endfunction

endpackage

### rtl/core/ft8_qso_auto_sequencer.sv
// ----------------------------------------------------------------------------
// ft8_qso_auto_sequencer
// Auto-sequencer for one FT8 contact: classifies decodes and steps a
// seven-state machine with per-step retry limits.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one command per request:
//   start CQ, touch, decode, slot tick or fetch. Each request gives exactly
//   one response on rsp (rsp_valid/rsp_ready/rsp) showing the state after
//   the update.
//   A request accepted is registered in stage 1 and its response is then
//   registered in the response register.
//   Throughput: one request per cycle while rsp is taken; the state update
//   is a single pass of classifier, compares and muxing between the stage 1
//   register and the response register.
//   If the receiver stalls, one response waits in the output register and one
//   more request is held in stage 1; req_ready then drops until rsp is taken.
//   Reset clears the contact state, loads the default registers (retry limit
//   two) and empties both stages.
//   cfg_we writes register cfg_idx from cfg_wdata; write only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ft8_qso_auto_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_idx,
	input  logic [ft8qso_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  ft8qso_pkg::req_t                     req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output ft8qso_pkg::rsp_t                     rsp
);

	// configuration
	logic [ft8qso_pkg::CALL_W-1:0] my_call_q;
	logic [3:0]                    max_retries_q;
	logic                          skip_first_q;
	logic                          beacon_q;

	// contact state
	logic [2:0]                    mode_q;
	logic [2:0]                    pending_q;
	logic [3:0]                    retries_used_q;
	logic [3:0]                    retries_allowed_q;
	logic [ft8qso_pkg::CALL_W-1:0] dx_call_q;
	logic signed [7:0]             snr_q;
	logic signed [7:0]             rsl_q;
	logic                          logged_q;

	// stage 1 and response register
	ft8qso_pkg::req_t req_s1;
	logic             valid_s1;
	ft8qso_pkg::rsp_t rsp_q;
	logic             rsp_valid_q;
	logic             advance;

	// next-state values
	logic [2:0]                    n_mode;
	logic [2:0]                    n_pend;
	logic [3:0]                    n_used;
	logic [3:0]                    n_allow;
	logic [ft8qso_pkg::CALL_W-1:0] n_dx;
	logic signed [7:0]             n_snr;
	logic signed [7:0]             n_rsl;
	logic                          n_logged;
	logic                          need;
	logic                          pulse;
	logic [2:0]                    kind;
	logic                          to_me;
	logic                          do_resp;
	logic                          force_step;
	logic                          resp_need;

	// terms used by the checks
	logic                          fetch_adv;
	logic                          rsp_late_msg;
	logic                          rsp_no_msg;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_call_q     <= '0;
			max_retries_q <= ft8qso_pkg::MAX_RETRIES_RST;
			skip_first_q  <= 1'b0;
			beacon_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ft8qso_pkg::CFG_MY_CALL:     my_call_q     <= cfg_wdata[ft8qso_pkg::CALL_W-1:0];
				ft8qso_pkg::CFG_MAX_RETRIES: max_retries_q <= cfg_wdata[3:0];
				ft8qso_pkg::CFG_SKIP_FIRST:  skip_first_q  <= cfg_wdata[0];
				ft8qso_pkg::CFG_BEACON:      beacon_q      <= cfg_wdata[0];
			endcase
		end
	end

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// sequencer update for the request in stage 1
	always_comb begin
		n_mode     = mode_q;
		n_pend     = pending_q;
		n_used     = retries_used_q;
		n_allow    = retries_allowed_q;
		n_dx       = dx_call_q;
		n_snr      = snr_q;
		n_rsl      = rsl_q;
		n_logged   = logged_q;
		need       = 1'b0;
		pulse      = 1'b0;
		do_resp    = 1'b0;
		force_step = 1'b0;
		resp_need  = 1'b0;
		kind       = ft8qso_pkg::classify(req_s1.report_text, req_s1.is_grid);
		to_me      = (req_s1.call_to == my_call_q);

		unique case (req_s1.command)
			ft8qso_pkg::CMD_CQ: begin
				n_dx    = ft8qso_pkg::CQ_CODE;
				n_mode  = ft8qso_pkg::ST_CALLING;
				n_pend  = ft8qso_pkg::MSG_CQ;
				n_used  = 4'd0;
				n_allow = 4'd0;
			end
			ft8qso_pkg::CMD_TOUCH: begin
				if (to_me) begin
					do_resp    = 1'b1;
					force_step = 1'b1;
				end else begin
					// foreign decode taken as a CQ from the sender
					n_dx    = req_s1.sender_call;
					n_snr   = req_s1.decode_snr;
					n_used  = 4'd0;
					n_allow = max_retries_q;
					if (skip_first_q) begin
						n_mode = ft8qso_pkg::ST_REPORT;
						n_pend = ft8qso_pkg::MSG_TX2;
					end else begin
						n_mode = ft8qso_pkg::ST_REPLYING;
						n_pend = ft8qso_pkg::MSG_TX1;
					end
				end
			end
			ft8qso_pkg::CMD_DECODE: begin
				// mid-contact, only the current partner may advance us
				if (to_me && !((mode_q == ft8qso_pkg::ST_REPLYING ||
						mode_q == ft8qso_pkg::ST_REPORT ||
						mode_q == ft8qso_pkg::ST_ROGER_REPORT) &&
						req_s1.sender_call != dx_call_q)) begin
					do_resp = 1'b1;
				end
			end
			ft8qso_pkg::CMD_TICK: begin
				unique case (mode_q)
					ft8qso_pkg::ST_REPLYING, ft8qso_pkg::ST_REPORT,
					ft8qso_pkg::ST_ROGER_REPORT, ft8qso_pkg::ST_ROGERS: begin
						if (retries_used_q < retries_allowed_q) begin
							// resend the message of this step
							n_used = retries_used_q + 4'd1;
							unique case (mode_q)
								ft8qso_pkg::ST_REPLYING: n_pend = ft8qso_pkg::MSG_TX1;
								ft8qso_pkg::ST_REPORT:   n_pend = ft8qso_pkg::MSG_TX2;
								ft8qso_pkg::ST_ROGER_REPORT: n_pend = ft8qso_pkg::MSG_TX3;
								default:                 n_pend = ft8qso_pkg::MSG_TX4;
							endcase
						end else if (mode_q == ft8qso_pkg::ST_ROGERS) begin
							n_mode   = ft8qso_pkg::ST_IDLE;
							n_pend   = ft8qso_pkg::MSG_NONE;
							n_logged = 1'b0;
						end else begin
							n_mode = ft8qso_pkg::ST_SIGNOFF;
							n_pend = ft8qso_pkg::MSG_TX5;
						end
					end
					ft8qso_pkg::ST_CALLING, ft8qso_pkg::ST_SIGNOFF: begin
						n_mode   = ft8qso_pkg::ST_IDLE;
						n_pend   = ft8qso_pkg::MSG_NONE;
						n_logged = 1'b0;
					end
					default: ;
				endcase
			end
			ft8qso_pkg::CMD_FETCH: begin
				if ((pending_q == ft8qso_pkg::MSG_TX4 || pending_q == ft8qso_pkg::MSG_TX5) &&
						!logged_q) begin
					n_logged = 1'b1;
					pulse    = 1'b1;
				end
				if (pending_q != ft8qso_pkg::MSG_NONE) begin
					// give up once a nonzero limit is spent
					if (retries_allowed_q != 4'd0 && retries_used_q >= retries_allowed_q) begin
						n_mode = ft8qso_pkg::ST_SIGNOFF;
					end
					need = 1'b1;
				end
			end
			default: ;
		endcase

		// response to a decode addressed to us
		if (do_resp) begin
			n_dx  = req_s1.sender_call;
			n_snr = req_s1.decode_snr;
			if (force_step) begin
				// touch: align the state with the kind of message heard
				n_pend  = ft8qso_pkg::MSG_NONE;
				n_used  = 4'd0;
				n_allow = 4'd0;
				unique case (kind)
					ft8qso_pkg::MSG_TX1: n_mode = ft8qso_pkg::ST_CALLING;
					ft8qso_pkg::MSG_TX2: n_mode = ft8qso_pkg::ST_REPLYING;
					ft8qso_pkg::MSG_TX3: n_mode = ft8qso_pkg::ST_REPORT;
					ft8qso_pkg::MSG_TX4: n_mode = ft8qso_pkg::ST_ROGER_REPORT;
					default:             n_mode = ft8qso_pkg::ST_ROGERS;
				endcase
			end
			if (kind == ft8qso_pkg::MSG_TX2 || kind == ft8qso_pkg::MSG_TX3) begin
				n_rsl = req_s1.received_report;
			end
			if (n_mode == ft8qso_pkg::ST_IDLE && beacon_q) begin
				n_mode = ft8qso_pkg::ST_CALLING;
			end

			unique case (n_mode)
				ft8qso_pkg::ST_CALLING: begin
					if (kind == ft8qso_pkg::MSG_TX1) begin
						n_mode = ft8qso_pkg::ST_REPORT;
						n_pend = ft8qso_pkg::MSG_TX2;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end else if (kind == ft8qso_pkg::MSG_TX2) begin
						n_mode = ft8qso_pkg::ST_ROGER_REPORT;
						n_pend = ft8qso_pkg::MSG_TX3;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end else if (kind == ft8qso_pkg::MSG_TX3) begin
						n_mode = ft8qso_pkg::ST_ROGERS;
						n_pend = ft8qso_pkg::MSG_TX4;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end
				end
				ft8qso_pkg::ST_REPLYING: begin
					if (kind == ft8qso_pkg::MSG_TX2) begin
						n_mode = ft8qso_pkg::ST_ROGER_REPORT;
						n_pend = ft8qso_pkg::MSG_TX3;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end else if (kind == ft8qso_pkg::MSG_TX3) begin
						n_mode = ft8qso_pkg::ST_ROGERS;
						n_pend = ft8qso_pkg::MSG_TX4;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end else if (kind == ft8qso_pkg::MSG_TX4 || kind == ft8qso_pkg::MSG_TX5) begin
						n_mode = ft8qso_pkg::ST_SIGNOFF;
						n_pend = ft8qso_pkg::MSG_TX5;
						n_used = 4'd0;
						n_allow = 4'd0;
						resp_need = 1'b1;
					end
				end
				ft8qso_pkg::ST_REPORT: begin
					if (kind == ft8qso_pkg::MSG_TX3) begin
						n_mode = ft8qso_pkg::ST_ROGERS;
						n_pend = ft8qso_pkg::MSG_TX4;
						n_used = 4'd0;
						n_allow = max_retries_q;
						resp_need = 1'b1;
					end else if (kind == ft8qso_pkg::MSG_TX4 || kind == ft8qso_pkg::MSG_TX5) begin
						n_mode = ft8qso_pkg::ST_SIGNOFF;
						n_pend = ft8qso_pkg::MSG_TX5;
						n_used = 4'd0;
						n_allow = 4'd0;
						resp_need = 1'b1;
					end
				end
				ft8qso_pkg::ST_ROGER_REPORT: begin
					if (kind == ft8qso_pkg::MSG_TX4 || kind == ft8qso_pkg::MSG_TX5) begin
						n_mode = ft8qso_pkg::ST_SIGNOFF;
						n_pend = ft8qso_pkg::MSG_TX5;
						n_used = 4'd0;
						n_allow = 4'd0;
						resp_need = 1'b1;
					end
				end
				ft8qso_pkg::ST_ROGERS: begin
					// contact closes without a reply; the logged flag stays
					if (kind == ft8qso_pkg::MSG_TX4 || kind == ft8qso_pkg::MSG_TX5) begin
						n_mode = ft8qso_pkg::ST_IDLE;
						n_pend = ft8qso_pkg::MSG_NONE;
						n_used = 4'd0;
						n_allow = 4'd0;
					end
				end
				ft8qso_pkg::ST_SIGNOFF: begin
					if (kind != ft8qso_pkg::MSG_TX4) begin
						n_mode = ft8qso_pkg::ST_IDLE;
						n_pend = ft8qso_pkg::MSG_NONE;
						n_used = 4'd0;
						n_allow = 4'd0;
					end
				end
				default: ;
			endcase
			// a touch never asks for a transmission
			need = resp_need && !force_step;
		end
	end

	// contact state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= ft8qso_pkg::ST_IDLE;
			pending_q         <= ft8qso_pkg::MSG_NONE;
			retries_used_q    <= 4'd0;
			retries_allowed_q <= 4'd0;
			dx_call_q         <= '0;
			snr_q             <= 8'sd0;
			rsl_q             <= 8'sd0;
			logged_q          <= 1'b0;
		end else if (advance) begin
			mode_q            <= n_mode;
			pending_q         <= n_pend;
			retries_used_q    <= n_used;
			retries_allowed_q <= n_allow;
			dx_call_q         <= n_dx;
			snr_q             <= n_snr;
			rsl_q             <= n_rsl;
			logged_q          <= n_logged;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.tx_needed      <= need;
			rsp_q.next_msg       <= n_pend;
			rsp_q.seq_state      <= n_mode;
			rsp_q.retry_count    <= n_used;
			rsp_q.partner_call   <= n_dx;
			rsp_q.report_snr     <= n_snr;
			rsp_q.partner_report <= n_rsl;
			rsp_q.log_pulse      <= pulse;
		end
	end

	// checks
	assign fetch_adv    = advance && (req_s1.command == ft8qso_pkg::CMD_FETCH);
	assign rsp_late_msg = (rsp_q.next_msg == ft8qso_pkg::MSG_TX4) ||
	                      (rsp_q.next_msg == ft8qso_pkg::MSG_TX5);
	assign rsp_no_msg   = (rsp_q.next_msg == ft8qso_pkg::MSG_NONE);

	`ASSERT_PROP(a_ready_when_free, clk, arst_n, !rsp_valid_q |-> req_ready)
	`ASSERT_PROP(a_retry_bound, clk, arst_n, retries_used_q <= retries_allowed_q)
	`ASSERT_PROP(a_log_on_fetch, clk, arst_n, $rose(logged_q) |-> $past(fetch_adv))
	`ASSERT_PROP(a_pulse_msg, clk, arst_n, (rsp_valid_q && rsp_q.log_pulse) |-> rsp_late_msg)
	`ASSERT_NEVER(a_need_without_msg, clk, arst_n, rsp_valid_q && rsp_q.tx_needed && rsp_no_msg)

endmodule
